// File: design/ssfe_pkg.sv
package ssfe_pkg;

  // Default number of payload bytes held by each buffer.
  localparam int DEF_BUF_DEPTH = 32;

  // Both running XOR checksums start from this seed at every restart.
  localparam logic [7:0] CHECK_SEED = 8'h96;

  // Filler sent once the transmit payload and its checksum are out.
  localparam logic [7:0] PAD_BYTE = 8'hff;

  typedef enum logic [1:0] {
    OP_EXCHANGE = 2'd0,
    OP_WRITE_TX = 2'd1,
    OP_READ_RX  = 2'd2,
    OP_RESTART  = 2'd3
  } op_t;

  // Buffer controls from the framing logic to the buffer block.
  typedef struct packed {
    logic tx_we;
    logic rx_we;
    logic rx_take;
  } buf_ctl_t;

  // Address width of a buffer of the given depth, at least one bit.
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// File: design/ssfe_bufs.sv
module ssfe_bufs #(
  parameter int BUF_DEPTH = ssfe_pkg::DEF_BUF_DEPTH
) (
  input  logic                                       clk,
  input  ssfe_pkg::buf_ctl_t                         ctl,
  input  logic [ssfe_pkg::addr_w(BUF_DEPTH)-1:0]     tx_waddr,
  input  logic [7:0]                                 tx_wdata,
  input  logic [ssfe_pkg::addr_w(BUF_DEPTH)-1:0]     tx_raddr,
  output logic [7:0]                                 tx_rdata,
  input  logic [ssfe_pkg::addr_w(BUF_DEPTH)-1:0]     rx_waddr,
  input  logic [7:0]                                 rx_wdata,
  input  logic [ssfe_pkg::addr_w(BUF_DEPTH)-1:0]     rx_raddr,
  output logic [7:0]                                 rx_rdata
);
  import ssfe_pkg::*;

  logic [7:0] tx_mem [BUF_DEPTH];
  logic [7:0] rx_mem [BUF_DEPTH];
  logic [7:0] tx_rdata_r;
  logic [7:0] rx_rdata_r;

  // Transmit buffer: read every cycle, with a write to the same entry
  // forwarded so the registered data is never stale.
  always_ff @(posedge clk) begin
    if (ctl.tx_we) begin
      tx_mem[tx_waddr] <= tx_wdata;
    end
    if (ctl.tx_we && (tx_waddr == tx_raddr)) begin
      tx_rdata_r <= tx_wdata;
    end else begin
      tx_rdata_r <= tx_mem[tx_raddr];
    end
  end

  // Receive buffer: read only when a new request is taken in.
  always_ff @(posedge clk) begin
    if (ctl.rx_we) begin
      rx_mem[rx_waddr] <= rx_wdata;
    end
    if (ctl.rx_take) begin
      if (ctl.rx_we && (rx_waddr == rx_raddr)) begin
        rx_rdata_r <= rx_wdata;
      end else begin
        rx_rdata_r <= rx_mem[rx_raddr];
      end
    end
  end

  assign tx_rdata = tx_rdata_r;
  assign rx_rdata = rx_rdata_r;

endmodule

// File: design/spi_slave_frame_engine_core.sv
// Channel  Handshake            Fields, in order
// in_      in_valid/in_stall    operation rx_byte entry_index entry_value tx_length
// out_     out_valid/out_stall  tx_byte tx_valid frame_done rx_count rx_entry frames_seen
//
// A taken request sits in the input register, then moves to the result register and leaves
// from there; one request per cycle flows with no gaps while out_stall stays low, since the
// framing update is a single combinational pass between the two registers.
// Reset (rst_n low at a clock edge) arms a frame of zero transmit bytes; the buffers are
// not cleared, so an entry reads back only after it has been written.
// A stalled result holds both registers, and in_stall rises while a full input one is held.
module spi_slave_frame_engine_core #(
  parameter int BUF_DEPTH = ssfe_pkg::DEF_BUF_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_rx_byte,
  input  logic [4:0] in_entry_index,
  input  logic [7:0] in_entry_value,
  input  logic [5:0] in_tx_length,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_valid,
  output logic       out_frame_done,
  output logic [5:0] out_rx_count,
  output logic [7:0] out_rx_entry,
  output logic [7:0] out_frames_seen
);
  import ssfe_pkg::*;

  localparam int AW    = addr_w(BUF_DEPTH);
  // Lengths and the byte position never exceed BUF_DEPTH + 1.
  localparam int LEN_W = $clog2(BUF_DEPTH + 2);

  // Input register.
  logic       in_valid_r;
  op_t        op_r;
  logic [7:0] rxb_r;
  logic [4:0] idx_r;
  logic [7:0] val_r;
  logic [5:0] len_r;
  logic       rd_ok_r;

  // Result register.
  logic       out_valid_r;
  logic [7:0] tx_byte_r;
  logic       tx_valid_r;
  logic       frame_done_r;
  logic [5:0] rx_count_r;
  logic [7:0] rx_entry_r;
  logic [7:0] frames_seen_r;

  // Framing state.
  logic [LEN_W-1:0] position_r, position_nxt;
  logic [LEN_W-1:0] send_len_r, send_len_nxt;
  logic [LEN_W-1:0] recv_len_r, recv_len_nxt;
  logic [LEN_W-1:0] frame_len_r, frame_len_nxt;
  logic [7:0]       send_check_r, send_check_nxt;
  logic [7:0]       recv_check_r, recv_check_nxt;
  logic [7:0]       frame_cnt_r, frame_cnt_nxt;
  logic             active_r, active_nxt;

  logic             in_accept;
  logic             fire;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] slot;
  logic [7:0]       rc;
  logic [7:0]       txb;
  logic             txv;
  logic             done;
  logic [7:0]       entry;
  logic             rx_we;
  buf_ctl_t         ctl;
  logic [7:0]       tx_rdata;
  logic [7:0]       rx_rdata;

  // The request in the input register moves on whenever the result register
  // is empty or its result is being taken this cycle.
  assign fire      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;

  assign len_sat = (32'(len_r) > BUF_DEPTH) ? LEN_W'(BUF_DEPTH) : LEN_W'(len_r);
  assign slot    = position_r - LEN_W'(1);
  assign rc      = recv_check_r ^ rxb_r;

  always_comb begin
    position_nxt   = position_r;
    send_len_nxt   = send_len_r;
    recv_len_nxt   = recv_len_r;
    frame_len_nxt  = frame_len_r;
    send_check_nxt = send_check_r;
    recv_check_nxt = recv_check_r;
    frame_cnt_nxt  = frame_cnt_r;
    active_nxt     = active_r;
    txb            = 8'h00;
    txv            = 1'b0;
    done           = 1'b0;
    entry          = 8'h00;
    rx_we          = 1'b0;

    if (fire) begin
      unique case (op_r)
        OP_RESTART: begin
          // Abandon any running frame and hand out the length byte first.
          position_nxt   = '0;
          send_len_nxt   = len_sat;
          frame_len_nxt  = len_sat + LEN_W'(1);
          recv_check_nxt = CHECK_SEED;
          active_nxt     = 1'b1;
          txb            = 8'(len_sat);
          txv            = 1'b1;
          send_check_nxt = CHECK_SEED ^ 8'(len_sat);
        end
        OP_WRITE_TX: begin
          // The buffer write itself is driven below.
        end
        OP_READ_RX: begin
          entry = rd_ok_r ? rx_rdata : 8'h00;
        end
        OP_EXCHANGE: begin
          if (active_r) begin
            recv_check_nxt = rc;

            // Receive side: the master's length byte, then payload, then checksum.
            if (position_r == '0) begin
              if (32'(rxb_r) > BUF_DEPTH) begin
                // An oversize length collapses the frame to the checksum only.
                send_len_nxt  = '0;
                recv_len_nxt  = '0;
                frame_len_nxt = LEN_W'(1);
              end else begin
                recv_len_nxt = LEN_W'(rxb_r);
                if ((LEN_W'(rxb_r) + LEN_W'(1)) > frame_len_r) begin
                  frame_len_nxt = LEN_W'(rxb_r) + LEN_W'(1);
                end
              end
            end else if (slot < recv_len_r) begin
              rx_we = 1'b1;
            end else if (slot == recv_len_r) begin
              if (rc != 8'h00) begin
                recv_len_nxt = '0;
              end
            end

            // Transmit side, using the lengths as just updated.
            if (position_r < send_len_nxt) begin
              txb          = tx_rdata;
              txv          = 1'b1;
              position_nxt = position_r + LEN_W'(1);
            end else if (position_r == send_len_nxt) begin
              txb          = send_check_r;
              txv          = 1'b1;
              position_nxt = position_r + LEN_W'(1);
            end else if (position_r < frame_len_nxt) begin
              txb          = PAD_BYTE;
              txv          = 1'b1;
              position_nxt = position_r + LEN_W'(1);
            end else begin
              frame_cnt_nxt = frame_cnt_r + 8'd1;
              active_nxt    = 1'b0;
              done          = 1'b1;
            end

            if (txv) begin
              send_check_nxt = send_check_r ^ txb;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ctl.tx_we   = fire && (op_r == OP_WRITE_TX) && (32'(idx_r) < BUF_DEPTH);
  assign ctl.rx_we   = rx_we;
  assign ctl.rx_take = in_accept;

  // The transmit buffer is read ahead at the next position, so the byte for
  // the coming exchange is already registered when that request fires.
  ssfe_bufs #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_bufs (
    .clk      (clk),
    .ctl      (ctl),
    .tx_waddr (AW'(idx_r)),
    .tx_wdata (val_r),
    .tx_raddr (AW'(position_nxt)),
    .tx_rdata (tx_rdata),
    .rx_waddr (AW'(slot)),
    .rx_wdata (rxb_r),
    .rx_raddr (AW'(in_entry_index)),
    .rx_rdata (rx_rdata)
  );

  // Handshake control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Framing state; reset is a zero-length restart that also clears recv_len and frame_cnt.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      send_len_r   <= '0;
      recv_len_r   <= '0;
      frame_len_r  <= LEN_W'(1);
      send_check_r <= CHECK_SEED;
      recv_check_r <= CHECK_SEED;
      frame_cnt_r  <= 8'd0;
      active_r     <= 1'b1;
    end else begin
      position_r   <= position_nxt;
      send_len_r   <= send_len_nxt;
      recv_len_r   <= recv_len_nxt;
      frame_len_r  <= frame_len_nxt;
      send_check_r <= send_check_nxt;
      recv_check_r <= recv_check_nxt;
      frame_cnt_r  <= frame_cnt_nxt;
      active_r     <= active_nxt;
    end
  end

  // Input payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= op_t'(in_operation);
      rxb_r   <= in_rx_byte;
      idx_r   <= in_entry_index;
      val_r   <= in_entry_value;
      len_r   <= in_tx_length;
      rd_ok_r <= (32'(in_entry_index) < BUF_DEPTH);
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      tx_byte_r     <= txb;
      tx_valid_r    <= txv;
      frame_done_r  <= done;
      rx_count_r    <= 6'(recv_len_nxt);
      rx_entry_r    <= entry;
      frames_seen_r <= frame_cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tx_byte     = tx_byte_r;
  assign out_tx_valid    = tx_valid_r;
  assign out_frame_done  = frame_done_r;
  assign out_rx_count    = rx_count_r;
  assign out_rx_entry    = rx_entry_r;
  assign out_frames_seen = frames_seen_r;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

// Bench for the SPI slave framing core. Every request that the core accepts
// runs through a cycle-free predictor of the framer held in this module. Each
// result that leaves the core is checked against the oldest prediction still
// outstanding. A short table of directed requests comes first. A long random
// phase follows, built mostly from well-formed frames.
module tb;
  import ssfe_pkg::*;

  localparam int BUF_DEPTH = DEF_BUF_DEPTH;
  localparam int N_DIRECTED = 22;
  localparam int RANDOM_ITEMS = 1350;
  // No correct run goes this many cycles without a handshake on either side.
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
    logic [4:0] index;
    logic [7:0] value;
    logic [5:0] tx_len;
  } request_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       frame_done;
    logic [5:0] rx_count;
    logic [7:0] rx_entry;
    logic [7:0] frames_seen;
  } frame_result_t;

  // One row of the directed table. When typed is set, the result is the
  // hand-written one rather than the one from the predictor.
  typedef struct packed {
    request_t      req;
    logic          typed;
    frame_result_t want;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation = '0;
  logic [7:0] in_rx_byte = '0;
  logic [4:0] in_entry_index = '0;
  logic [7:0] in_entry_value = '0;
  logic [5:0] in_tx_length = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_tx_byte;
  logic       out_tx_valid;
  logic       out_frame_done;
  logic [5:0] out_rx_count;
  logic [7:0] out_rx_entry;
  logic [7:0] out_frames_seen;

  spi_slave_frame_engine_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_rx_byte     (in_rx_byte),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_tx_length   (in_tx_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_byte    (out_tx_byte),
    .out_tx_valid   (out_tx_valid),
    .out_frame_done (out_frame_done),
    .out_rx_count   (out_rx_count),
    .out_rx_entry   (out_rx_entry),
    .out_frames_seen(out_frames_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Framer state as the predictor sees it. The reset values are the same as
  // those of a restart with a transmit length of zero.
  logic [7:0] fr_pos = '0;
  logic [5:0] fr_send_len = '0;
  logic [5:0] fr_recv_len = '0;
  logic [5:0] fr_frame_len = 6'd1;
  logic [7:0] fr_send_chk = CHECK_SEED;
  logic [7:0] fr_recv_chk = CHECK_SEED;
  logic [7:0] fr_rx_mem [BUF_DEPTH];
  logic [7:0] fr_tx_mem [BUF_DEPTH];
  logic [7:0] fr_frames = '0;
  logic       fr_armed = 1'b1;

  // Buffer entries that hold a defined value. The stimulus never reads any
  // other entry, neither by a receive read nor by sending transmit payload.
  bit tx_written [BUF_DEPTH];
  bit rx_written [BUF_DEPTH];

  frame_result_t expected_results [$];
  frame_result_t seen_result;
  frame_result_t due_result;
  plan_row_t     plan [N_DIRECTED];

  // While calm is set, neither side idles or stalls.
  bit calm = 1'b0;
  int n_errors = 0;
  int n_requests = 0;
  int n_frames = 0;
  int n_bad_check = 0;
  int n_oversize = 0;
  int n_saturated = 0;
  int quiet_cycles = 0;

  // Applies one request to the predicted framer and returns its result.
  function automatic frame_result_t step_framer(input request_t rq);
    frame_result_t r;
    int len;
    int slot;
    logic [7:0] b;
    r = '0;
    case (rq.op)
      OP_RESTART: begin
        // A transmit length above the buffer size is clipped, and the clipped
        // value goes out as the length byte.
        if (rq.tx_len > BUF_DEPTH) begin
          len = BUF_DEPTH;
          n_saturated++;
        end else begin
          len = int'(rq.tx_len);
        end
        fr_pos = '0;
        fr_send_len = 6'(len);
        fr_frame_len = 6'(len + 1);
        fr_recv_chk = CHECK_SEED;
        fr_armed = 1'b1;
        r.tx_byte = 8'(len);
        r.tx_valid = 1'b1;
        fr_send_chk = CHECK_SEED ^ r.tx_byte;
      end
      OP_WRITE_TX: begin
        if (rq.index < BUF_DEPTH) begin
          fr_tx_mem[rq.index] = rq.value;
          tx_written[rq.index] = 1'b1;
        end
      end
      OP_READ_RX: begin
        if (rq.index < BUF_DEPTH) begin
          r.rx_entry = fr_rx_mem[rq.index];
        end
      end
      OP_EXCHANGE: begin
        // An exchange with no frame armed leaves everything as it is.
        if (fr_armed) begin
          fr_recv_chk = fr_recv_chk ^ rq.rx_byte;
          if (fr_pos == 0) begin
            // The first byte from the master is its payload length. A length
            // that does not fit the buffer empties both directions.
            if (rq.rx_byte > BUF_DEPTH) begin
              fr_send_len = '0;
              fr_recv_len = '0;
              fr_frame_len = 6'd1;
              n_oversize++;
            end else begin
              fr_recv_len = rq.rx_byte[5:0];
              if (int'(rq.rx_byte) + 1 > int'(fr_frame_len)) begin
                fr_frame_len = 6'(int'(rq.rx_byte) + 1);
              end
            end
          end else begin
            slot = int'(fr_pos) - 1;
            if (slot < int'(fr_recv_len)) begin
              if (slot < BUF_DEPTH) begin
                fr_rx_mem[slot] = rq.rx_byte;
                rx_written[slot] = 1'b1;
              end
            end else if (slot == int'(fr_recv_len) && fr_recv_chk != 8'h00) begin
              // The byte after the payload is the checksum, and the XOR over
              // the whole frame must come out as zero.
              fr_recv_len = '0;
              n_bad_check++;
            end
          end

          if (fr_pos < fr_send_len) begin
            b = fr_tx_mem[fr_pos[4:0]];
          end else if (fr_pos == fr_send_len) begin
            b = fr_send_chk;
          end else begin
            b = PAD_BYTE;
          end
          if (fr_pos <= fr_send_len || fr_pos < fr_frame_len) begin
            r.tx_byte = b;
            r.tx_valid = 1'b1;
            fr_send_chk = fr_send_chk ^ b;
            fr_pos++;
          end else begin
            // The exchange after the last byte closes the frame.
            fr_frames++;
            fr_armed = 1'b0;
            r.frame_done = 1'b1;
            n_frames++;
          end
        end
      end
    endcase
    r.rx_count = fr_recv_len;
    r.frames_seen = fr_frames;
    return r;
  endfunction

  // Offers one request, starting at a falling edge, with a random gap first.
  // Once the request is taken, its result is predicted and queued. The task
  // returns at the next falling edge with in_valid still high, so a request
  // that follows at once keeps the valid up without a dip.
  task automatic issue(input request_t rq, input logic typed, input frame_result_t want);
    frame_result_t predicted;
    while (!calm && $urandom_range(99) < 11) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_operation = rq.op;
    in_rx_byte = rq.rx_byte;
    in_entry_index = rq.index;
    in_entry_value = rq.value;
    in_tx_length = rq.tx_len;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    predicted = step_framer(rq);
    expected_results.push_back(typed ? want : predicted);
    n_requests++;
    @(negedge clk);
  endtask

  task automatic push_request(input op_t op, input logic [7:0] rx, input logic [4:0] idx,
                              input logic [7:0] val, input logic [5:0] len);
    request_t rq;
    rq = '{op, rx, idx, val, len};
    issue(rq, 1'b0, '0);
  endtask

  // The sender holds off until every outstanding result has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Writes every transmit entry that a frame of this length would send and
  // that has not yet been written.
  task automatic fill_send_entries(input logic [5:0] len);
    for (int i = 0; i < int'(len) && i < BUF_DEPTH; i++) begin
      if (!tx_written[i]) begin
        push_request(OP_WRITE_TX, 8'($urandom), 5'(i), 8'($urandom), 6'($urandom));
      end
    end
  endtask

  // A read of some written receive entry, or a random transmit write when no
  // read is asked for or no receive entry holds data yet.
  task automatic buffer_access(input bit want_read);
    int start;
    int idx;
    int k;
    idx = -1;
    if (want_read) begin
      start = $urandom_range(BUF_DEPTH - 1);
      for (k = 0; k < BUF_DEPTH; k++) begin
        if (idx < 0 && rx_written[(start + k) % BUF_DEPTH]) begin
          idx = (start + k) % BUF_DEPTH;
        end
      end
    end
    if (idx >= 0) begin
      push_request(OP_READ_RX, 8'($urandom), 5'(idx), 8'($urandom), 6'($urandom));
    end else begin
      push_request(OP_WRITE_TX, 8'($urandom), 5'($urandom), 8'($urandom), 6'($urandom));
    end
  endtask

  // One frame as a master would run it: restart, the length byte, payload and
  // checksum, then padding until the core closes the frame. Some checksums are
  // wrong on purpose, and a few frames are cut short by the next restart.
  task automatic run_frame();
    logic [5:0] len;
    logic [7:0] mlen;
    logic [7:0] b;
    logic [7:0] sum;
    int pick;
    int k;
    int stop_at;
    bit good;
    bit abandon;
    pick = $urandom_range(99);
    if (pick < 70) begin
      len = 6'($urandom_range(6));
    end else if (pick < 90) begin
      len = 6'($urandom_range(32, 7));
    end else begin
      len = 6'($urandom_range(63, 33));
    end
    repeat ($urandom_range(2)) buffer_access(1'b0);
    fill_send_entries(len);
    if ($urandom_range(9) == 0) begin
      buffer_access(1'b1);
    end
    push_request(OP_RESTART, 8'($urandom), 5'($urandom), 8'($urandom), len);

    pick = $urandom_range(99);
    if (pick < 70) begin
      mlen = 8'($urandom_range(6));
    end else if (pick < 90) begin
      mlen = 8'($urandom_range(32, 7));
    end else begin
      mlen = 8'($urandom_range(255, 33));
    end
    good = ($urandom_range(99) < 80);
    abandon = ($urandom_range(99) < 8);
    stop_at = $urandom_range(20, 1);
    sum = CHECK_SEED ^ mlen;
    k = 0;
    while (fr_armed && k < 40 && !(abandon && k == stop_at)) begin
      if (k == 0) begin
        b = mlen;
      end else if (mlen <= BUF_DEPTH && k <= int'(mlen)) begin
        b = 8'($urandom);
        sum = sum ^ b;
      end else if (mlen <= BUF_DEPTH && k == int'(mlen) + 1) begin
        b = good ? sum : sum ^ 8'($urandom_range(255, 1));
      end else begin
        b = 8'($urandom);
      end
      push_request(OP_EXCHANGE, b, 5'($urandom), 8'($urandom), 6'($urandom));
      k++;
      // Now and then the host touches the buffers in the middle of a frame.
      if ($urandom_range(99) < 4) begin
        buffer_access(1'($urandom_range(1)));
      end
    end
    // A stray exchange after the frame has closed must be ignored.
    if ($urandom_range(4) == 0) begin
      push_request(OP_EXCHANGE, 8'($urandom), 5'($urandom), 8'($urandom), 6'($urandom));
    end
  endtask

  // A few requests of random kind and content.
  task automatic noise_burst();
    op_t op;
    logic [5:0] len;
    repeat ($urandom_range(5, 1)) begin
      op = op_t'($urandom_range(3));
      case (op)
        OP_RESTART: begin
          len = 6'($urandom);
          fill_send_entries(len);
          push_request(OP_RESTART, 8'($urandom), 5'($urandom), 8'($urandom), len);
        end
        OP_WRITE_TX: begin
          buffer_access(1'b0);
        end
        OP_READ_RX: begin
          buffer_access(1'b1);
        end
        OP_EXCHANGE: begin
          push_request(OP_EXCHANGE, 8'($urandom), 5'($urandom), 8'($urandom), 6'($urandom));
        end
      endcase
    end
  endtask

  // The receiver stalls at random outside the calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 11);
  end

  // Result checker and watchdog. Both look at values from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_result = {out_tx_byte, out_tx_valid, out_frame_done, out_rx_count,
                       out_rx_entry, out_frames_seen};
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("unexpected result: tx %h/%b done %b rx_count %0d entry %h frames %0d",
                     seen_result.tx_byte, seen_result.tx_valid, seen_result.frame_done,
                     seen_result.rx_count, seen_result.rx_entry, seen_result.frames_seen);
          end
        end else begin
          due_result = expected_results.pop_front();
          if (seen_result.tx_byte !== due_result.tx_byte ||
              seen_result.tx_valid !== due_result.tx_valid ||
              seen_result.frame_done !== due_result.frame_done ||
              seen_result.rx_count !== due_result.rx_count ||
              seen_result.rx_entry !== due_result.rx_entry ||
              seen_result.frames_seen !== due_result.frames_seen) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("mismatch: expected tx %h/%b done %b rx_count %0d entry %h frames %0d",
                       due_result.tx_byte, due_result.tx_valid, due_result.frame_done,
                       due_result.rx_count, due_result.rx_entry, due_result.frames_seen);
              $display("          got      tx %h/%b done %b rx_count %0d entry %h frames %0d",
                       seen_result.tx_byte, seen_result.tx_valid, seen_result.frame_done,
                       seen_result.rx_count, seen_result.rx_entry, seen_result.frames_seen);
            end
          end
        end
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int rounds;
    rounds = 0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      fr_rx_mem[i] = '0;
      fr_tx_mem[i] = '0;
    end

    // Directed table. Results are typed in where they follow at once from
    // the reset state or from a clipped length; the rest come from the
    // predictor.
    // An empty frame right after reset: the master sends length zero and the
    // seed as its checksum, then the frame closes and the count steps.
    plan[0]  = '{'{OP_EXCHANGE, 8'h00, 5'd0,  8'h00, 6'd0},  1'b1,
                 {8'h96, 1'b1, 1'b0, 6'd0, 8'h00, 8'd0}};
    plan[1]  = '{'{OP_EXCHANGE, 8'h96, 5'd0,  8'h00, 6'd0},  1'b1,
                 {8'h00, 1'b0, 1'b1, 6'd0, 8'h00, 8'd1}};
    // An exchange while no frame is armed.
    plan[2]  = '{'{OP_EXCHANGE, 8'hff, 5'd31, 8'hff, 6'd63}, 1'b1,
                 {8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'd1}};
    // Transmit writes at both ends of the buffer, two of them with extreme values.
    plan[3]  = '{'{OP_WRITE_TX, 8'h00, 5'd0,  8'h00, 6'd0},  1'b1,
                 {8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'd1}};
    plan[4]  = '{'{OP_WRITE_TX, 8'hff, 5'd1,  8'hff, 6'd63}, 1'b1,
                 {8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'd1}};
    plan[5]  = '{'{OP_WRITE_TX, 8'h5a, 5'd31, 8'ha5, 6'd21}, 1'b1,
                 {8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'd1}};
    // A two-byte frame each way with a good checksum, then read back.
    plan[6]  = '{'{OP_RESTART,  8'h00, 5'd0,  8'h00, 6'd2},  1'b1,
                 {8'h02, 1'b1, 1'b0, 6'd0, 8'h00, 8'd1}};
    plan[7]  = '{'{OP_EXCHANGE, 8'h02, 5'd0,  8'h00, 6'd0},  1'b0, '0};
    plan[8]  = '{'{OP_EXCHANGE, 8'hab, 5'd0,  8'h00, 6'd0},  1'b0, '0};
    plan[9]  = '{'{OP_EXCHANGE, 8'h55, 5'd0,  8'h00, 6'd0},  1'b0, '0};
    plan[10] = '{'{OP_EXCHANGE, 8'h6a, 5'd0,  8'h00, 6'd0},  1'b0, '0};
    plan[11] = '{'{OP_READ_RX,  8'h00, 5'd0,  8'h00, 6'd0},  1'b0, '0};
    plan[12] = '{'{OP_READ_RX,  8'h00, 5'd1,  8'h00, 6'd0},  1'b0, '0};
    // The largest transmit length is clipped to the buffer size.
    plan[13] = '{'{OP_RESTART,  8'h00, 5'd0,  8'h00, 6'd63}, 1'b1,
                 {8'h20, 1'b1, 1'b0, 6'd2, 8'h00, 8'd2}};
    // A restart abandons that frame, then the master sends an oversize
    // length and a wrong checksum.
    plan[14] = '{'{OP_RESTART,  8'h00, 5'd0,  8'h00, 6'd1},  1'b0, '0};
    plan[15] = '{'{OP_EXCHANGE, 8'h28, 5'd0,  8'h00, 6'd0},  1'b0, '0};
    plan[16] = '{'{OP_EXCHANGE, 8'h00, 5'd0,  8'h00, 6'd0},  1'b0, '0};
    // One payload byte from the master with a wrong checksum: the count drops
    // to zero, but the byte stays in the buffer.
    plan[17] = '{'{OP_RESTART,  8'h00, 5'd0,  8'h00, 6'd0},  1'b0, '0};
    plan[18] = '{'{OP_EXCHANGE, 8'h01, 5'd0,  8'h00, 6'd0},  1'b0, '0};
    plan[19] = '{'{OP_EXCHANGE, 8'h10, 5'd0,  8'h00, 6'd0},  1'b0, '0};
    plan[20] = '{'{OP_EXCHANGE, 8'h00, 5'd0,  8'h00, 6'd0},  1'b0, '0};
    plan[21] = '{'{OP_READ_RX,  8'h00, 5'd0,  8'h00, 6'd0},  1'b0, '0};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      issue(plan[i].req, plan[i].typed, plan[i].want);
    end
    drain_results();

    // Random phase. Most rounds are whole frames. A stretch in the middle
    // runs with no gaps and no stalls, and every so often the sender waits
    // for the core to empty.
    while (n_requests < N_DIRECTED + RANDOM_ITEMS) begin
      calm = (n_requests >= 500 && n_requests < 760);
      if ($urandom_range(9) == 0) begin
        noise_burst();
      end else begin
        run_frame();
      end
      rounds++;
      if (rounds % 45 == 0) begin
        drain_results();
      end
    end
    calm = 1'b0;

    drain_results();
    // A few more cycles, to catch a result that should not come.
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      n_errors += expected_results.size();
      $display("%0d results never arrived", expected_results.size());
    end

    $display("Covered %0d requests in %0d rounds: %0d frames closed, %0d bad checksums,",
             n_requests, rounds, n_frames, n_bad_check);
    $display("%0d oversize master lengths and %0d clipped transmit lengths.",
             n_oversize, n_saturated);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
